>>> rtl/core/gbn_pkg.sv
// Shared types and codes for the go-back-N sender window control.
// Used by gbn_ctrl, gbn_dpath, go_back_n_sender and tb_top; no dependencies.
`default_nettype none
package gbn_pkg;

	// counters hold a 16-bit sequence plus one
	localparam int CNT_W = 17;

	localparam logic [1:0] ACT_START   = 2'd0;
	localparam logic [1:0] ACT_REPLY   = 2'd1;
	localparam logic [1:0] ACT_TIMEOUT = 2'd2;
	localparam logic [1:0] ACT_RXERR   = 2'd3;

	localparam logic [1:0] RTYPE_ACK = 2'd1;

	localparam logic [1:0] KIND_SEND    = 2'd0;
	localparam logic [1:0] KIND_RUNNING = 2'd1;
	localparam logic [1:0] KIND_OK      = 2'd2;
	localparam logic [1:0] KIND_FAILED  = 2'd3;

	localparam logic CFG_WIN_LEN     = 1'b0;
	localparam logic CFG_FRAME_COUNT = 1'b1;

	// what the output register is loaded from
	typedef enum logic [2:0] {
		SRC_SCAN,
		SRC_NEXT,
		SRC_RUN,
		SRC_END,
		SRC_FAIL
	} emit_src_t;

	typedef struct packed {
		logic      load_in;
		logic      start_clr;
		logic      ack_upd;
		logic      scan_init;
		logic      emit;
		emit_src_t emit_src;
	} gbn_cmd_t;

	typedef struct packed {
		logic [1:0] action;
		logic       finished;
		logic       win_zero;
		logic       scan_lt_next;
		logic       base_done;
		logic       fill_ok;
		logic       out_free;
	} gbn_sts_t;

endpackage
`default_nettype wire

>>> rtl/core/go_back_n_sender.sv
// Top level of the go-back-N sender window control.
// Joins gbn_ctrl and gbn_dpath; uses gbn_pkg.
//
// Each accepted event (start, reply, timeout, receive error) produces a run
// of send-frame results followed by one status result with last set. The
// block takes one event at a time: in_ready is high only between events.
// Results leave through a registered output at one per cycle while out_ready
// stays high. Besides its results, an event passes through capture, decide,
// end check and the exits of the resend and fill walks, and in those walks
// the sequencer steps one frame index per cycle while the output is free.
// Write the window and frame count registers only while no event is in
// progress.
`default_nettype none
module go_back_n_sender
	import gbn_pkg::*;
#(
	parameter int WINDOW_MAX = 16,
	parameter int SEQ_BITS   = 16
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic        cfg_index,
	input  wire logic [15:0] cfg_wdata,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [1:0]  action,
	input  wire logic        decode_ok,
	input  wire logic [1:0]  reply_type,
	input  wire logic [15:0] reply_seq,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [1:0]       kind,
	output logic [15:0]      frame_index,
	output logic             last
);

	gbn_cmd_t cmd;
	gbn_sts_t sts;

	gbn_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	gbn_dpath #(
		.WINDOW_MAX (WINDOW_MAX),
		.SEQ_BITS   (SEQ_BITS)
	) u_dpath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_wdata   (cfg_wdata),
		.action      (action),
		.decode_ok   (decode_ok),
		.reply_type  (reply_type),
		.reply_seq   (reply_seq),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.kind        (kind),
		.frame_index (frame_index),
		.last        (last),
		.cmd         (cmd),
		.sts         (sts)
	);

endmodule
`default_nettype wire

>>> rtl/core/gbn_ctrl.sv
// Sequencer for the go-back-N sender: walks one event through decide,
// resend, end check, window fill and status. Uses gbn_pkg.
`default_nettype none
module gbn_ctrl
	import gbn_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     in_valid,
	output logic          in_ready,
	input  wire gbn_sts_t sts,
	output gbn_cmd_t      cmd
);

	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_DECIDE = 3'd1;
	localparam logic [2:0] ST_RESEND = 3'd2;
	localparam logic [2:0] ST_CHECK  = 3'd3;
	localparam logic [2:0] ST_FILL   = 3'd4;
	localparam logic [2:0] ST_RUN    = 3'd5;
	localparam logic [2:0] ST_END    = 3'd6;
	localparam logic [2:0] ST_FAIL   = 3'd7;

	logic [2:0] state_q;
	logic [2:0] state_d;

	assign in_ready = (state_q == ST_IDLE);

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		cmd.emit_src = SRC_RUN;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.load_in = 1'b1;
					state_d     = ST_DECIDE;
				end
			end
			ST_DECIDE: begin
				if (sts.finished && sts.action != ACT_START) begin
					state_d = ST_END;
				end else begin
					unique case (sts.action)
						ACT_START: begin
							cmd.start_clr = 1'b1;
							state_d = sts.win_zero ? ST_END : ST_CHECK;
						end
						ACT_REPLY: begin
							cmd.ack_upd = 1'b1;
							state_d     = ST_CHECK;
						end
						ACT_TIMEOUT: begin
							cmd.scan_init = 1'b1;
							state_d       = ST_RESEND;
						end
						default: state_d = ST_FAIL;
					endcase
				end
			end
			ST_RESEND: begin
				if (!sts.scan_lt_next) begin
					state_d = ST_CHECK;
				end else if (sts.out_free) begin
					cmd.emit     = 1'b1;
					cmd.emit_src = SRC_SCAN;
				end
			end
			ST_CHECK: begin
				state_d = sts.base_done ? ST_END : ST_FILL;
			end
			ST_FILL: begin
				if (!sts.fill_ok) begin
					state_d = ST_RUN;
				end else if (sts.out_free) begin
					cmd.emit     = 1'b1;
					cmd.emit_src = SRC_NEXT;
				end
			end
			ST_RUN: begin
				if (sts.out_free) begin
					cmd.emit     = 1'b1;
					cmd.emit_src = SRC_RUN;
					state_d      = ST_IDLE;
				end
			end
			ST_END: begin
				if (sts.out_free) begin
					cmd.emit     = 1'b1;
					cmd.emit_src = SRC_END;
					state_d      = ST_IDLE;
				end
			end
			ST_FAIL: begin
				if (sts.out_free) begin
					cmd.emit     = 1'b1;
					cmd.emit_src = SRC_FAIL;
					state_d      = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule
`default_nettype wire

>>> rtl/core/gbn_dpath.sv
// Datapath for the go-back-N sender: window counters, config registers,
// captured event and the output register. Uses gbn_pkg.
`default_nettype none
module gbn_dpath
	import gbn_pkg::*;
#(
	parameter int WINDOW_MAX = 16,
	parameter int SEQ_BITS   = 16
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic        cfg_index,
	input  wire logic [15:0] cfg_wdata,
	input  wire logic [1:0]  action,
	input  wire logic        decode_ok,
	input  wire logic [1:0]  reply_type,
	input  wire logic [15:0] reply_seq,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [1:0]       kind,
	output logic [15:0]      frame_index,
	output logic             last,
	input  wire gbn_cmd_t    cmd,
	output gbn_sts_t         sts
);

	localparam int SEQ_USE = (SEQ_BITS < 16) ? SEQ_BITS : 16;
	localparam int WM_BITS = $clog2(WINDOW_MAX + 1);
	localparam int WIN_W   = (WM_BITS > 5) ? WM_BITS : 5;
	localparam logic [15:0] SEQ_MASK = 16'((17'd1 << SEQ_USE) - 17'd1);
	localparam logic [WIN_W-1:0] WMAX = WIN_W'(WINDOW_MAX);

	logic [4:0]       win_len_q;
	logic [15:0]      frame_count_q;
	logic [CNT_W-1:0] base_q;
	logic [CNT_W-1:0] next_q;
	logic [CNT_W-1:0] scan_q;
	logic             finished_q;

	logic [1:0]  action_q;
	logic        decode_ok_q;
	logic [1:0]  reply_type_q;
	logic [15:0] reply_seq_q;

	logic        out_valid_q;
	logic [1:0]  kind_q;
	logic [15:0] frame_index_q;
	logic        last_q;

	logic [CNT_W-1:0] seq_ext;
	logic [CNT_W-1:0] ack_base;
	logic             ack_hit;
	logic [WIN_W-1:0] ws_ext;
	logic [WIN_W-1:0] eff_win;
	logic [CNT_W:0]   win_end;
	logic [CNT_W-1:0] fc_ext;
	logic [1:0]       end_kind;

	assign seq_ext  = {1'b0, reply_seq_q & SEQ_MASK};
	assign ack_base = seq_ext + CNT_W'(1);
	assign ack_hit  = decode_ok_q && (reply_type_q == RTYPE_ACK) && (seq_ext >= base_q);

	assign ws_ext  = WIN_W'(win_len_q);
	assign eff_win = (ws_ext > WMAX) ? WMAX : ws_ext;
	assign win_end = {1'b0, base_q} + (CNT_W + 1)'(eff_win);
	assign fc_ext  = {1'b0, frame_count_q};
	assign end_kind = (base_q == fc_ext) ? KIND_OK : KIND_FAILED;

	always_comb begin
		sts.action       = action_q;
		sts.finished     = finished_q;
		sts.win_zero     = (win_len_q == 5'd0);
		sts.scan_lt_next = (scan_q < next_q);
		sts.base_done    = (base_q >= fc_ext);
		sts.fill_ok      = (next_q < fc_ext) && ({1'b0, next_q} < win_end);
		sts.out_free     = !out_valid_q || out_ready;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_len_q     <= 5'd4;
			frame_count_q <= 16'd0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_WIN_LEN:     win_len_q     <= cfg_wdata[4:0];
				CFG_FRAME_COUNT: frame_count_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// captured event fields
	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			action_q     <= action;
			decode_ok_q  <= decode_ok;
			reply_type_q <= reply_type;
			reply_seq_q  <= reply_seq;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q     <= '0;
			next_q     <= '0;
			scan_q     <= '0;
			finished_q <= 1'b0;
		end else begin
			if (cmd.start_clr) begin
				base_q     <= '0;
				next_q     <= '0;
				finished_q <= sts.win_zero;
			end
			if (cmd.ack_upd && ack_hit) begin
				base_q <= ack_base;
				// never leave next below the base
				if (next_q < ack_base) begin
					next_q <= ack_base;
				end
			end
			if (cmd.scan_init) begin
				scan_q <= base_q;
			end
			if (cmd.emit) begin
				case (cmd.emit_src)
					SRC_SCAN: scan_q <= scan_q + CNT_W'(1);
					SRC_NEXT: next_q <= next_q + CNT_W'(1);
					SRC_END, SRC_FAIL: finished_q <= 1'b1;
					default: ;
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			case (cmd.emit_src)
				SRC_SCAN: begin
					kind_q        <= KIND_SEND;
					frame_index_q <= scan_q[15:0];
					last_q        <= 1'b0;
				end
				SRC_NEXT: begin
					kind_q        <= KIND_SEND;
					frame_index_q <= next_q[15:0];
					last_q        <= 1'b0;
				end
				SRC_RUN: begin
					kind_q        <= KIND_RUNNING;
					frame_index_q <= 16'd0;
					last_q        <= 1'b1;
				end
				SRC_END: begin
					kind_q        <= end_kind;
					frame_index_q <= 16'd0;
					last_q        <= 1'b1;
				end
				default: begin
					kind_q        <= KIND_FAILED;
					frame_index_q <= 16'd0;
					last_q        <= 1'b1;
				end
			endcase
		end
	end

	assign out_valid   = out_valid_q;
	assign kind        = kind_q;
	assign frame_index = frame_index_q;
	assign last        = last_q;

endmodule
`default_nettype wire

>>> sim/tb_top.sv
// Testbench for go_back_n_sender: directed and random window sessions with a
// self-checking window tracker. Depends on gbn_pkg and go_back_n_sender only.
`timescale 1ns / 100ps

import gbn_pkg::*;

typedef struct packed {
	logic [1:0]  kind;
	logic [15:0] frame_index;
	logic        last;
} send_result_t;

class gbn_window_tracker;
	localparam int WIN_MAX = 16;

	logic [4:0]   win_size    = 5'd4;
	logic [15:0]  frame_total = 16'd0;
	logic [16:0]  window_base = '0;
	logic [16:0]  next_seq    = '0;
	logic         finished    = 1'b0;
	int           mismatches  = 0;
	send_result_t due_results[$];

	task report(string msg);
		$display("%0t ns mismatch: %s", $time, msg);
		mismatches++;
	endtask

	function void set_reg(logic idx, logic [15:0] val);
		if (idx == CFG_WIN_LEN) begin
			win_size = val[4:0];
		end else begin
			frame_total = val;
		end
	endfunction

	function int pending();
		return due_results.size();
	endfunction

	function void push(logic [1:0] k, logic [15:0] idx, logic l);
		send_result_t r;
		r.kind        = k;
		r.frame_index = idx;
		r.last        = l;
		due_results.insert(due_results.size(), r);
	endfunction

	function logic [1:0] end_kind();
		return (window_base == {1'b0, frame_total}) ? KIND_OK : KIND_FAILED;
	endfunction

	// note an accepted event and queue the results it must produce
	function void apply_event(logic [1:0] act, logic dok, logic [1:0] rtype,
			logic [15:0] seq);
		logic [16:0] i;
		logic [17:0] limit;
		int          eff;
		if (finished && act != ACT_START) begin
			push(end_kind(), 16'd0, 1'b1);
			return;
		end
		case (act)
			ACT_START: begin
				window_base = '0;
				next_seq    = '0;
				finished    = 1'b0;
				if (win_size == 5'd0) begin
					finished = 1'b1;
					push(end_kind(), 16'd0, 1'b1);
					return;
				end
			end
			ACT_REPLY: begin
				if (dok && rtype == RTYPE_ACK && {1'b0, seq} >= window_base) begin
					window_base = {1'b0, seq} + 17'd1;
					if (next_seq < window_base)
						next_seq = window_base;
				end
			end
			ACT_TIMEOUT: begin
				for (i = window_base; i < next_seq; i = i + 17'd1)
					push(KIND_SEND, i[15:0], 1'b0);
			end
			default: begin
				finished = 1'b1;
				push(KIND_FAILED, 16'd0, 1'b1);
				return;
			end
		endcase
		if (window_base >= {1'b0, frame_total}) begin
			finished = 1'b1;
			push(end_kind(), 16'd0, 1'b1);
			return;
		end
		eff   = (win_size > WIN_MAX) ? WIN_MAX : int'(win_size);
		limit = {1'b0, window_base} + 18'(eff);
		while (next_seq < {1'b0, frame_total} && {1'b0, next_seq} < limit) begin
			push(KIND_SEND, next_seq[15:0], 1'b0);
			next_seq = next_seq + 17'd1;
		end
		push(KIND_RUNNING, 16'd0, 1'b1);
	endfunction

	task match_result(logic [1:0] k, logic [15:0] idx, logic l);
		send_result_t e;
		if (due_results.size() == 0) begin
			report($sformatf("unexpected result kind %0d index %0d last %0d", k, idx, l));
			return;
		end
		e = due_results.pop_front();
		if (k !== e.kind)
			report($sformatf("kind %0d, want %0d", k, e.kind));
		if (idx !== e.frame_index)
			report($sformatf("frame_index %0d, want %0d", idx, e.frame_index));
		if (l !== e.last)
			report($sformatf("last %0d, want %0d", l, e.last));
	endtask
endclass

module tb_top;
	localparam logic [1:0] RTYPE_DATA = 2'd0;
	localparam logic [1:0] RTYPE_NAK  = 2'd2;
	localparam logic [1:0] RTYPE_FIN  = 2'd3;
	localparam int STALL_LIMIT = 2000;
	localparam int HOLD_CYCLES = 300;
	localparam int ITEM_TARGET = 170;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic        cfg_index = 1'b0;
	logic [15:0] cfg_wdata = '0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [1:0]  action = '0;
	logic        decode_ok = 1'b0;
	logic [1:0]  reply_type = '0;
	logic [15:0] reply_seq = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [1:0]  kind;
	logic [15:0] frame_index;
	logic        last;

	gbn_window_tracker tracker = new();
	int events_sent = 0;
	int idle_cycles = 0;
	bit rx_hold_req = 1'b0;

	go_back_n_sender uut (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
		.in_valid(in_valid), .in_ready(in_ready),
		.action(action), .decode_ok(decode_ok), .reply_type(reply_type),
		.reply_seq(reply_seq),
		.out_valid(out_valid), .out_ready(out_ready),
		.kind(kind), .frame_index(frame_index), .last(last)
	);

	always #5 clk = ~clk;

	// mostly short gaps, a few long ones
	function int pick_gap(int floor_cycles);
		int r;
		r = $urandom_range(0, 99);
		if (r < 70) return floor_cycles + $urandom_range(0, 1) * floor_cycles;
		if (r < 90) return floor_cycles + $urandom_range(1, 3);
		if (r < 98) return floor_cycles + $urandom_range(4, 12);
		return floor_cycles + $urandom_range(20, 50);
	endfunction

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			tracker.match_result(kind, frame_index, last);
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready)) begin
				idle_cycles <= 0;
			end else if (idle_cycles >= STALL_LIMIT) begin
				$display("tb_top: errors");
				$finish;
			end else begin
				idle_cycles <= idle_cycles + 1;
			end
		end
	end

	// receiver: random ready bursts, occasional clean stretches, one long hold
	initial begin
		wait (arst_n);
		@(negedge clk);
		forever begin
			if (rx_hold_req) begin
				out_ready = 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
				rx_hold_req = 1'b0;
			end else if ($urandom_range(0, 7) == 0) begin
				out_ready = 1'b1;
				repeat ($urandom_range(40, 100)) @(negedge clk);
			end else begin
				out_ready = 1'b1;
				repeat ($urandom_range(1, 8)) @(negedge clk);
				out_ready = 1'b0;
				repeat (pick_gap(1)) @(negedge clk);
			end
		end
	end

	task send(logic [1:0] act, logic dok, logic [1:0] rtype, logic [15:0] seq);
		int gap;
		action     = act;
		decode_ok  = dok;
		reply_type = rtype;
		reply_seq  = seq;
		in_valid   = 1'b1;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		tracker.apply_event(act, dok, rtype, seq);
		events_sent++;
		@(negedge clk);
		gap = pick_gap(0);
		if (gap > 0) begin
			in_valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
	endtask

	task ack(logic [15:0] seq);
		send(ACT_REPLY, 1'b1, RTYPE_ACK, seq);
	endtask

	// drop valid and let the block drain before touching registers
	task settle();
		in_valid = 1'b0;
		while (tracker.pending() != 0) @(negedge clk);
		repeat (8) @(negedge clk);
	endtask

	task write_reg(logic idx, logic [15:0] val);
		cfg_we    = 1'b1;
		cfg_index = idx;
		cfg_wdata = val;
		@(negedge clk);
		cfg_we = 1'b0;
		tracker.set_reg(idx, val);
	endtask

	task run_session(int n_events);
		int r;
		int k;
		int lo;
		int hi;
		r = $urandom_range(0, 9);
		write_reg(CFG_WIN_LEN, (r == 0) ? 16'd0 : (r == 1) ? 16'd16 :
			(r == 2) ? 16'd1 : 16'($urandom_range(1, 16)));
		r = $urandom_range(0, 19);
		write_reg(CFG_FRAME_COUNT, (r == 0) ? 16'd0 : (r == 1) ? 16'hFFFF :
			(r < 4) ? 16'($urandom_range(100, 65535)) : 16'($urandom_range(1, 48)));
		send(ACT_START, 1'($urandom), 2'($urandom), 16'($urandom));
		k = 0;
		while (k < n_events && !(tracker.finished && $urandom_range(0, 2) == 0)) begin
			r  = $urandom_range(0, 99);
			lo = (tracker.window_base > 0) ? int'(tracker.window_base) - 1 : 0;
			hi = int'(tracker.next_seq) + 2;
			if (lo > 65535) lo = 65535;
			if (hi > 65535) hi = 65535;
			if (r < 5)
				ack(tracker.frame_total - 16'd1);
			else if (r < 55)
				ack(16'($urandom_range(lo, hi)));
			else if (r < 70)
				send(ACT_TIMEOUT, 1'($urandom), 2'($urandom), 16'($urandom));
			else if (r < 85)
				send(ACT_REPLY, 1'($urandom), 2'($urandom), 16'($urandom));
			else if (r < 88)
				send(ACT_RXERR, 1'($urandom), 2'($urandom), 16'($urandom));
			else if (r < 91)
				send(ACT_START, 1'($urandom), 2'($urandom), 16'($urandom));
			else if (r < 94) begin
				// resize the window in the middle of a session
				settle();
				write_reg(CFG_WIN_LEN, 16'($urandom_range(0, 16)));
			end else
				ack(16'($urandom));
			k++;
		end
		settle();
	endtask

	initial begin
		int s;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// reset settings: events ahead of any start, then an empty session
		ack(16'd0);
		send(ACT_TIMEOUT, 1'b0, RTYPE_DATA, 16'd0);
		send(ACT_START, 1'b0, RTYPE_DATA, 16'd0);
		settle();

		write_reg(CFG_WIN_LEN, 16'd16);
		write_reg(CFG_FRAME_COUNT, 16'd40);
		send(ACT_START, 1'b1, RTYPE_FIN, 16'hFFFF);
		send(ACT_TIMEOUT, 1'b1, RTYPE_ACK, 16'd0);
		send(ACT_REPLY, 1'b0, RTYPE_ACK, 16'd5);
		send(ACT_REPLY, 1'b1, RTYPE_NAK, 16'd5);
		send(ACT_REPLY, 1'b1, RTYPE_DATA, 16'd6);
		send(ACT_REPLY, 1'b1, RTYPE_FIN, 16'd7);
		ack(16'd3);
		ack(16'd30);          // beyond what was sent
		ack(16'd2);           // below the base
		send(ACT_TIMEOUT, 1'b0, RTYPE_NAK, 16'd0);
		ack(16'd39);          // session completes
		send(ACT_TIMEOUT, 1'b0, RTYPE_DATA, 16'd0);
		send(ACT_RXERR, 1'b0, RTYPE_DATA, 16'd0);
		send(ACT_START, 1'b0, RTYPE_DATA, 16'd0);
		send(ACT_RXERR, 1'b1, RTYPE_ACK, 16'd1);
		ack(16'd0);
		settle();

		write_reg(CFG_WIN_LEN, 16'd0);
		send(ACT_START, 1'b0, RTYPE_DATA, 16'd0);
		settle();
		write_reg(CFG_FRAME_COUNT, 16'd0);
		send(ACT_START, 1'b0, RTYPE_DATA, 16'd0);
		settle();

		write_reg(CFG_WIN_LEN, 16'd8);
		write_reg(CFG_FRAME_COUNT, 16'd100);
		send(ACT_START, 1'b0, RTYPE_DATA, 16'd0);
		settle();
		write_reg(CFG_WIN_LEN, 16'd2);
		ack(16'd2);
		send(ACT_TIMEOUT, 1'b0, RTYPE_DATA, 16'd0);
		ack(16'hFFFF);        // base runs past the frame count
		settle();

		write_reg(CFG_WIN_LEN, 16'd16);
		write_reg(CFG_FRAME_COUNT, 16'hFFFF);
		send(ACT_START, 1'b0, RTYPE_DATA, 16'd0);
		ack(16'hFFFE);
		settle();

		s = 0;
		while (events_sent < ITEM_TARGET) begin
			// hold the receiver off so the block backs up into its input
			if (s == 1)
				rx_hold_req = 1'b1;
			run_session($urandom_range(4, 16));
			s++;
		end

		settle();
		repeat (40) @(posedge clk);
		if (tracker.mismatches == 0 && tracker.pending() == 0)
			$display("tb_top: clean");
		else
			$display("tb_top: errors");
		$finish;
	end
endmodule
